[src/pfc_pkg.sv]
// Shared types, constants and small cell arithmetic helpers for the Playfair engine.
// No dependencies; every other file of the block but pfc_ram imports this package.
package pfc_pkg;

  localparam int NumLetters = 26;
  localparam int NumCells   = 25;

  localparam logic [4:0] LETTER_COUNT = 5'd26;
  localparam logic [4:0] CELL_COUNT   = 5'd25;
  localparam logic [4:0] LETTER_I     = 5'd8;
  localparam logic [4:0] LETTER_J     = 5'd9;
  localparam logic [4:0] LETTER_X     = 5'd23;
  localparam logic [4:0] LAST_LETTER  = 5'd25;
  localparam logic [2:0] LAST_INDEX   = 3'd4;

  typedef enum logic [2:0] {
    KIND_KEY_START   = 3'd0,
    KIND_KEY_LETTER  = 3'd1,
    KIND_KEY_END     = 3'd2,
    KIND_TEXT_LETTER = 3'd3,
    KIND_TEXT_END    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CMD_KEY_START,
    CMD_KEY_LETTER,
    CMD_KEY_END,
    CMD_PAIR
  } cmd_op_e;

  // One command from the front end to the execution unit.
  typedef struct packed {
    cmd_op_e    op;
    logic [4:0] a;     // key letter, or first letter of a pair
    logic [4:0] b;     // second letter of a pair
    logic       dec;   // pair is decrypted
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_KEY_END,
    BK_POS_B,
    BK_CELL1,
    BK_EMIT1,
    BK_EMIT2
  } back_state_e;

  // Row of a cell index 0..24.
  function automatic logic [2:0] cell_row(input logic [4:0] p);
    logic [2:0] r;
    if (p < 5'd5) begin
      r = 3'd0;
    end else if (p < 5'd10) begin
      r = 3'd1;
    end else if (p < 5'd15) begin
      r = 3'd2;
    end else if (p < 5'd20) begin
      r = 3'd3;
    end else begin
      r = 3'd4;
    end
    return r;
  endfunction

  function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
  endfunction

  function automatic logic [2:0] cell_col(input logic [4:0] p);
    logic [4:0] rem;
    rem = p - cell_of(cell_row(p), 3'd0);
    return rem[2:0];
  endfunction

  // One step around a row or column, forward or backward modulo five.
  function automatic logic [2:0] step5(input logic [2:0] v, input logic back);
    logic [2:0] s;
    if (back) begin
      s = (v == 3'd0) ? LAST_INDEX : v - 3'd1;
    end else begin
      s = (v == LAST_INDEX) ? 3'd0 : v + 3'd1;
    end
    return s;
  endfunction

endpackage

[src/pfc_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module pfc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/pfc_front.sv]
// Front end: accepts input items, folds j onto i, drops invalid items and
// gathers text letters into pairs. Depends on pfc_pkg.
module pfc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    in_kind_i,
  input  logic [4:0]    in_letter_i,
  input  logic          decrypt_mode_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output pfc_pkg::cmd_t push_cmd_o
);
  import pfc_pkg::*;

  logic       pend_valid_q, pend_valid_d;
  logic [4:0] pend_letter_q, pend_letter_d;
  logic       accept;
  logic [4:0] l;
  logic       in_range;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & push_ready_i;
  assign l          = (in_letter_i == LETTER_J) ? LETTER_I : in_letter_i;
  assign in_range   = (l < LETTER_COUNT);

  always_comb begin
    pend_valid_d  = pend_valid_q;
    pend_letter_d = pend_letter_q;
    push_valid_o  = 1'b0;
    push_cmd_o    = '{op: CMD_KEY_START, a: l, b: LETTER_X, dec: decrypt_mode_i};
    if (accept) begin
      case (kind_e'(in_kind_i))
        KIND_KEY_START: begin
          push_valid_o  = 1'b1;
          pend_valid_d  = 1'b0;
          pend_letter_d = '0;
        end
        KIND_KEY_LETTER: begin
          push_valid_o  = in_range;
          push_cmd_o.op = CMD_KEY_LETTER;
        end
        KIND_KEY_END: begin
          push_valid_o  = 1'b1;
          push_cmd_o.op = CMD_KEY_END;
        end
        KIND_TEXT_LETTER: begin
          push_cmd_o.op = CMD_PAIR;
          push_cmd_o.a  = pend_letter_q;
          if (in_range) begin
            if (!pend_valid_q) begin
              pend_valid_d  = 1'b1;
              pend_letter_d = l;
            end else if (!decrypt_mode_i && (l == pend_letter_q)) begin
              // A doubled letter is split by x and stays held for the next pair.
              push_valid_o = 1'b1;
            end else begin
              push_valid_o  = 1'b1;
              push_cmd_o.b  = l;
              pend_valid_d  = 1'b0;
            end
          end
        end
        KIND_TEXT_END: begin
          push_cmd_o.op = CMD_PAIR;
          push_cmd_o.a  = pend_letter_q;
          push_valid_o  = pend_valid_q;
          pend_valid_d  = 1'b0;
        end
        default: begin
          push_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q  <= 1'b0;
      pend_letter_q <= '0;
    end else begin
      pend_valid_q  <= pend_valid_d;
      pend_letter_q <= pend_letter_d;
    end
  end

endmodule

[src/pfc_queue.sv]
// Small command queue between the front end and the execution unit.
// Depends on pfc_pkg for the command type.
module pfc_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  pfc_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output pfc_pkg::cmd_t pop_cmd_o
);
  import pfc_pkg::*;

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  cmd_t            slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[src/pfc_back.sv]
// Execution unit: builds the key square and substitutes letter pairs.
// Depends on pfc_pkg and pfc_ram (key square and letter position memories).
module pfc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  input  pfc_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [4:0]    out_letter_o,
  output logic          out_last_o
);
  import pfc_pkg::*;

  back_state_e state_q, state_d;

  logic [NumLetters-1:0] used_q, used_d;
  logic [4:0]            fill_q, fill_d;
  logic [4:0]            idx_q, idx_d;
  logic [4:0]            b_q, b_d;
  logic                  dec_q, dec_d;
  logic [4:0]            p1_q, p1_d;
  logic [4:0]            n2_q, n2_d;
  logic                  out_valid_q, out_valid_d;
  logic [4:0]            out_letter_q, out_letter_d;
  logic                  out_last_q, out_last_d;

  // Placement of one letter into the next free cell.
  logic       place_req;
  logic [4:0] place_letter;
  logic       place_ok;

  logic       pos_re, sq_re;
  logic [4:0] pos_raddr, sq_raddr;
  logic [4:0] pos_rdata, sq_rdata;

  logic       out_free;
  logic [4:0] p1, p2, n1, n2;
  logic [2:0] r1, c1, r2, c2;

  assign out_free = !out_valid_q || out_ready_i;
  assign place_ok = place_req && !used_q[place_letter] && (fill_q < CELL_COUNT);

  // Entries never written may hold anything; keep the cell index in range.
  assign p1 = (p1_q < CELL_COUNT) ? p1_q : '0;
  assign p2 = (pos_rdata < CELL_COUNT) ? pos_rdata : '0;
  assign r1 = cell_row(p1);
  assign c1 = cell_col(p1);
  assign r2 = cell_row(p2);
  assign c2 = cell_col(p2);

  always_comb begin
    if (r1 == r2) begin
      n1 = cell_of(r1, step5(c1, dec_q));
      n2 = cell_of(r2, step5(c2, dec_q));
    end else if (c1 == c2) begin
      n1 = cell_of(step5(r1, dec_q), c1);
      n2 = cell_of(step5(r2, dec_q), c2);
    end else begin
      n1 = cell_of(r1, c2);
      n2 = cell_of(r2, c1);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            CMD_KEY_END: state_d = BK_KEY_END;
            CMD_PAIR:    state_d = BK_POS_B;
            default:     state_d = BK_IDLE;
          endcase
        end
      end
      BK_KEY_END: begin
        if (idx_q == LAST_LETTER) begin
          state_d = BK_IDLE;
        end
      end
      BK_POS_B: state_d = BK_CELL1;
      BK_CELL1: state_d = BK_EMIT1;
      BK_EMIT1: begin
        if (out_free) begin
          state_d = BK_EMIT2;
        end
      end
      BK_EMIT2: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    cmd_pop_o    = 1'b0;
    used_d       = used_q;
    fill_d       = fill_q;
    idx_d        = idx_q;
    b_d          = b_q;
    dec_d        = dec_q;
    p1_d         = p1_q;
    n2_d         = n2_q;
    place_req    = 1'b0;
    place_letter = cmd_i.a;
    pos_re       = 1'b0;
    pos_raddr    = cmd_i.a;
    sq_re        = 1'b0;
    sq_raddr     = n1;
    out_letter_d = out_letter_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_ready_i ? 1'b0 : out_valid_q;

    case (state_q)
      BK_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        if (cmd_valid_i) begin
          case (cmd_i.op)
            CMD_KEY_START: begin
              used_d           = '0;
              used_d[LETTER_J] = 1'b1;
              fill_d           = '0;
            end
            CMD_KEY_LETTER: begin
              place_req = 1'b1;
            end
            CMD_KEY_END: begin
              idx_d = '0;
            end
            CMD_PAIR: begin
              pos_re = 1'b1;
              b_d    = cmd_i.b;
              dec_d  = cmd_i.dec;
            end
            default: begin
              place_req = 1'b0;
            end
          endcase
        end
      end
      BK_KEY_END: begin
        place_req    = 1'b1;
        place_letter = idx_q;
        idx_d        = idx_q + 5'd1;
      end
      BK_POS_B: begin
        p1_d      = pos_rdata;
        pos_re    = 1'b1;
        pos_raddr = b_q;
      end
      BK_CELL1: begin
        sq_re = 1'b1;
        n2_d  = n2;
      end
      BK_EMIT1: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_letter_d = sq_rdata;
          out_last_d   = 1'b0;
          sq_re        = 1'b1;
          sq_raddr     = n2_q;
        end
      end
      BK_EMIT2: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_letter_d = sq_rdata;
          out_last_d   = 1'b1;
        end
      end
      default: begin
        cmd_pop_o = 1'b0;
      end
    endcase

    if (place_ok) begin
      used_d[place_letter] = 1'b1;
      fill_d               = fill_q + 5'd1;
    end
  end

  pfc_ram #(.WIDTH(5), .DEPTH(NumCells)) u_square (
    .clk_i   (clk_i),
    .we_i    (place_ok),
    .waddr_i (fill_q),
    .wdata_i (place_letter),
    .re_i    (sq_re),
    .raddr_i (sq_raddr),
    .rdata_o (sq_rdata)
  );

  pfc_ram #(.WIDTH(5), .DEPTH(NumLetters)) u_position (
    .clk_i   (clk_i),
    .we_i    (place_ok),
    .waddr_i (place_letter),
    .wdata_i (fill_q),
    .re_i    (pos_re),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    b_q          <= b_d;
    dec_q        <= dec_d;
    p1_q         <= p1_d;
    n2_q         <= n2_d;
    out_letter_q <= out_letter_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      used_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_letter_o = out_letter_q;
  assign out_last_o   = out_last_q;

endmodule

[src/playfair_digraph_cipher.sv]
// Top level of the Playfair digraph cipher engine.
// Depends on pfc_pkg, pfc_front, pfc_queue and pfc_back.
//
// This block runs the classic 5x5 Playfair cipher on letters coded a=0 to
// z=25, with j folded onto i. Each input item carries a kind on tuser (key
// start, key letter, key end, text letter, text end) and a letter in the low
// five bits of tdata. A key start clears the square, key letters fill it in
// order of first appearance, and a key end appends the unused letters in
// alphabet order. Text letters are gathered into pairs; in encrypt mode a
// doubled letter is split by x and carried into the next pair, and an odd
// tail is padded with x at text end. Every pair yields two output items, the
// second one marked by tlast. The front end takes one item per cycle as long
// as its command queue has room, and items that complete no pair or key step
// push no command. Behind the queue, the execution unit handles a key start
// or key letter in its idle state, walks all 26 alphabet letters on a key
// end, and for each pair makes two reads of the letter position memory, then
// two reads of the key square memory, each memory having a single read port;
// a stalled output holds it. It takes a new command only from its idle
// state, so it finishes a pair before it takes the next. The decrypt_mode
// register is written through cfg_we_i and cfg_wdata_i; the user must write
// it only while the block is idle, as the block itself does not enforce it.
module playfair_digraph_cipher #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,     // decrypt_mode

  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [4:0] letter, [7:5] zero
  input  logic [2:0] s_axis_tuser,    // [2:0] kind

  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [4:0] out_letter, [7:5] zero
  output logic       m_axis_tlast     // last
);
  import pfc_pkg::*;

  logic       decrypt_mode_q;
  logic       push_valid, push_ready;
  cmd_t       push_cmd;
  logic       pop_valid, pop;
  cmd_t       pop_cmd;
  logic [4:0] out_letter;

  // The mode register is sampled by the front end when a pair is formed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      decrypt_mode_q <= cfg_wdata_i;
    end
  end

  pfc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_kind_i      (s_axis_tuser),
    .in_letter_i    (s_axis_tdata[4:0]),
    .decrypt_mode_i (decrypt_mode_q),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_cmd_o     (push_cmd)
  );

  pfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_cmd_o    (pop_cmd)
  );

  pfc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (pop_valid),
    .cmd_pop_o    (pop),
    .cmd_i        (pop_cmd),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_letter_o (out_letter),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_letter};

endmodule
